[rtl/cstrip_pkg.sv]
// Shared types and character codes for the C comment stripper.
`default_nettype none

package cstrip_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;

	// Scanner state carried from one byte to the next
	typedef struct packed {
		logic [7:0] held_byte;
		logic       seen_any;
		logic       held_printable;
		logic       in_line_comment;
		logic       in_block_comment;
		logic       in_string;
		logic       after_backslash;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		held_byte:        8'h00,
		seen_any:         1'b0,
		held_printable:   1'b0,
		in_line_comment:  1'b0,
		in_block_comment: 1'b0,
		in_string:        1'b0,
		after_backslash:  1'b0
	};

	// One output beat, with its valid flag
	typedef struct packed {
		logic       valid;
		logic [7:0] out_byte;
		logic       out_last;
	} scan_result_t;

endpackage

`default_nettype wire

[rtl/c_comment_stripper_top.sv]
// Top level of the C comment stripper: stream ports, scan state, output buffering.
//
// Strips C line and block comments from a byte stream, leaving double-quoted
// strings and backslash-escaped bytes intact. One beat is taken every clock
// while s_tready is high; each byte is emitted one beat late, since the
// scanner holds a byte back to drop a slash that opens a comment. A beat with
// s_tlast high is a flush: its data is ignored, the held byte goes out (if it
// is kept) with m_tlast high, and the scanner clears. Throughput is one beat
// per cycle while the master side is ready, set by the scan-state update. A
// result is registered in the output register (or in the skid register while
// the master side stalls) before it appears on the master side. The skid
// register absorbs one result while the master side stalls; s_tready then
// stays low until that result moves into the output register.
`default_nettype none

module c_comment_stripper_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Slave side
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // end_flush
	// Master side
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast    // out_last
);
	import cstrip_pkg::*;

	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t res;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       skid_valid_q;
	logic [7:0] skid_byte_q;
	logic       skid_last_q;

	logic accept;
	logic push;
	logic pop;

	cstrip_next u_next (
		.data_byte (s_tdata),
		.end_flush (s_tlast),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	assign s_tready = ~skid_valid_q;
	assign accept   = s_tvalid & s_tready;
	assign push     = accept & res.valid;
	assign pop      = out_valid_q & m_tready;

	// Advance scan state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output register and skid register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Load payloads: refill output from skid first, else from the new result
	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_byte_q <= skid_byte_q;
				out_last_q <= skid_last_q;
			end else begin
				out_byte_q <= res.out_byte;
				out_last_q <= res.out_last;
			end
		end else if (push) begin
			skid_byte_q <= res.out_byte;
			skid_last_q <= res.out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[rtl/cstrip_next.sv]
// Next-state and result logic for one source byte or flush.
`default_nettype none

module cstrip_next (
	input  wire logic [7:0]               data_byte,
	input  wire logic                     end_flush,
	input  wire cstrip_pkg::scan_state_t  cur,
	output cstrip_pkg::scan_state_t       nxt,
	output cstrip_pkg::scan_result_t      res
);
	import cstrip_pkg::*;

	logic emit_ok;
	logic slash_before;

	assign emit_ok      = cur.seen_any & cur.held_printable;
	assign slash_before = emit_ok & (cur.held_byte == CH_SLASH);

	// Classify the byte against the current scan mode
	always_comb begin
		nxt          = cur;
		res.valid    = 1'b0;
		res.out_byte = cur.held_byte;
		res.out_last = 1'b0;

		priority if (end_flush) begin
			// Emit the held byte as the last beat, then clear everything
			res.valid    = emit_ok;
			res.out_last = 1'b1;
			nxt          = SCAN_RESET;
		end else if (cur.after_backslash || data_byte == CH_BACKSLASH) begin
			res.valid           = emit_ok;
			nxt.held_printable  = ~cur.in_line_comment & ~cur.in_block_comment;
			nxt.after_backslash = ~cur.after_backslash;
			nxt.held_byte       = data_byte;
			nxt.seen_any        = 1'b1;
		end else if (cur.in_string) begin
			res.valid          = emit_ok;
			nxt.in_string      = (data_byte != CH_QUOTE);
			nxt.held_printable = 1'b1;
			nxt.held_byte      = data_byte;
			nxt.seen_any       = 1'b1;
		end else if (cur.in_line_comment) begin
			// A newline ends the comment and is kept
			nxt.held_printable  = (data_byte == CH_NEWLINE);
			nxt.in_line_comment = (data_byte != CH_NEWLINE);
			nxt.held_byte       = data_byte;
			nxt.seen_any        = 1'b1;
		end else if (cur.in_block_comment) begin
			nxt.held_printable = 1'b0;
			if (data_byte == CH_SLASH && cur.held_byte == CH_STAR) begin
				nxt.in_block_comment = 1'b0;
			end
			nxt.held_byte = data_byte;
			nxt.seen_any  = 1'b1;
		end else if (data_byte == CH_SLASH && slash_before) begin
			// Drop the held slash and open a line comment
			nxt.held_printable  = 1'b0;
			nxt.in_line_comment = 1'b1;
			nxt.held_byte       = data_byte;
			nxt.seen_any        = 1'b1;
		end else if (data_byte == CH_STAR && slash_before) begin
			// Drop the held slash; the star cannot close the comment
			nxt.held_printable   = 1'b0;
			nxt.in_block_comment = 1'b1;
			nxt.held_byte        = 8'h00;
			nxt.seen_any         = 1'b1;
		end else begin
			res.valid          = emit_ok;
			nxt.in_string      = (data_byte == CH_QUOTE);
			nxt.held_printable = 1'b1;
			nxt.held_byte      = data_byte;
			nxt.seen_any       = 1'b1;
		end
	end

endmodule

`default_nettype wire
